[rtl/swmad_pkg.sv]
// Package for the sliding-window mean / mean absolute deviation block.
// Field widths, fixed-point format and controller state type.
// No dependencies.
`default_nettype none

package swmad_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 16;
	localparam int MAD_W    = 24;
	localparam int FRAC_W   = 8;

	// largest deviation result: 65535 in Q16.8
	localparam logic [MAD_W-1:0] MAD_MAX = 24'd16776960;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_MLOAD,
		ST_MDIV,
		ST_MEND,
		ST_WALK,
		ST_ALOAD,
		ST_ADIV
	} state_t;

	typedef enum logic {
		DIV_MEAN,
		DIV_MAD
	} div_sel_t;

endpackage

`default_nettype wire

[rtl/swmad_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swmad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/sliding_window_mean_abs_deviation_top.sv]
// Sliding-window mean and mean absolute deviation, top level.
// Depends on swmad_pkg and swmad_ram.
//
// Each sample transfer enters a first-in first-out window of WINDOW samples held
// in one RAM; once the window is full the oldest sample leaves and is reported.
// The result carries the truncated mean and the mean absolute deviation (Q16.8).
// One item is processed at a time. The processing time of an item is set by
// the walk over the stored samples through the RAM's single read port and by
// the bit-serial divider, which runs once for the mean and once for the
// deviation. A finished result waits in the output register while the next
// sample is taken.
`default_nettype none

module sliding_window_mean_abs_deviation_top #(
	parameter int WINDOW = 128
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic signed [swmad_pkg::SAMPLE_W-1:0] sample,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic                                     evicted_valid,
	output logic signed [swmad_pkg::SAMPLE_W-1:0]    evicted_sample,
	output logic signed [swmad_pkg::MEAN_W-1:0]      window_mean,
	output logic        [swmad_pkg::MAD_W-1:0]       mean_abs_dev
);

	localparam int SW_  = swmad_pkg::SAMPLE_W;
	localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW   = $clog2(WINDOW + 1);
	localparam int SUMW = SW_ + CW;
	localparam int TW   = SW_ + CW;
	localparam int DW   = TW + swmad_pkg::FRAC_W;
	localparam int IW   = $clog2(DW + 1);

	swmad_pkg::state_t state_q, state_d;

	logic [AW-1:0]          ptr_q;
	logic [CW-1:0]          fill_q;
	logic signed [SUMW-1:0] sum_q;

	logic signed [SW_-1:0]  s_q;
	logic                   ev_valid_q;
	logic signed [SW_-1:0]  ev_q;
	logic signed [SW_-1:0]  mean_q;
	logic [TW-1:0]          total_q;
	logic                   neg_q;

	logic [DW-1:0]          dvd_q;
	logic [CW-1:0]          rem_q;
	logic [IW-1:0]          iter_q;

	logic [AW-1:0]          walk_addr_q;
	logic [CW-1:0]          issue_left_q;
	logic                   rd_s1;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [SW_-1:0]         ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [SW_-1:0]         ram_rdata;

	logic                   full;
	logic                   in_xfer;
	logic                   out_free;
	logic [AW:0]            tail_sum;
	logic [AW-1:0]          tail_addr;
	logic [AW-1:0]          ptr_inc;
	logic [AW-1:0]          walk_inc;
	logic [SUMW-1:0]        sum_mag;
	logic [CW:0]            rem_sh;
	logic                   qbit;
	logic [CW:0]            rem_diff;
	logic [SW_:0]           dev;
	logic [SW_-1:0]         dev_abs;
	logic [SW_:0]           quo_mean;
	logic                   finish;

	assign full     = (fill_q == CW'(WINDOW));
	assign in_xfer  = sample_valid && !sample_stall;
	assign out_free = !result_valid || !result_stall;

	assign tail_sum  = (AW+1)'(ptr_q) + (AW+1)'(fill_q);
	assign tail_addr = (tail_sum >= (AW+1)'(WINDOW)) ?
		AW'(tail_sum - (AW+1)'(WINDOW)) : AW'(tail_sum);
	assign ptr_inc   = (ptr_q == AW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
	assign walk_inc  = (walk_addr_q == AW'(WINDOW - 1)) ? '0 : walk_addr_q + 1'b1;

	assign sum_mag  = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	// restoring divider step, divisor is the fill count
	assign rem_sh   = {rem_q, dvd_q[DW-1]};
	assign qbit     = (rem_sh >= (CW+1)'(fill_q));
	assign rem_diff = rem_sh - (CW+1)'(fill_q);

	assign dev      = {mean_q[SW_-1], mean_q} - {ram_rdata[SW_-1], ram_rdata};
	assign dev_abs  = dev[SW_] ? SW_'(-dev) : SW_'(dev);

	assign quo_mean = dvd_q[SW_:0];

	assign finish   = (state_q == swmad_pkg::ST_ADIV) && (iter_q == IW'(1));

	swmad_ram #(
		.WIDTH(SW_),
		.DEPTH(WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		ram_we       = 1'b0;
		ram_waddr    = tail_addr;
		ram_wdata    = s_q;
		ram_re       = 1'b0;
		ram_raddr    = walk_addr_q;
		unique case (state_q)
			swmad_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					if (full) begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q;
						state_d   = swmad_pkg::ST_EVICT;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = sample;
						state_d   = swmad_pkg::ST_MLOAD;
					end
				end
			end
			swmad_pkg::ST_EVICT: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				state_d   = swmad_pkg::ST_MLOAD;
			end
			swmad_pkg::ST_MLOAD: begin
				state_d = swmad_pkg::ST_MDIV;
			end
			swmad_pkg::ST_MDIV: begin
				if (iter_q == IW'(1)) begin
					state_d = swmad_pkg::ST_MEND;
				end
			end
			swmad_pkg::ST_MEND: begin
				state_d = swmad_pkg::ST_WALK;
			end
			swmad_pkg::ST_WALK: begin
				ram_re = (issue_left_q != '0);
				if (issue_left_q == '0 && !rd_s1) begin
					state_d = swmad_pkg::ST_ALOAD;
				end
			end
			swmad_pkg::ST_ALOAD: begin
				state_d = swmad_pkg::ST_ADIV;
			end
			swmad_pkg::ST_ADIV: begin
				// hold the last step until the output register is free
				if (iter_q == IW'(1) && out_free) begin
					state_d = swmad_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swmad_pkg::ST_IDLE;
			end
		endcase
	end

	// window bookkeeping and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			rd_s1        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rd_s1 <= (state_q == swmad_pkg::ST_WALK) && (issue_left_q != '0);
			if (in_xfer && !full) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + SUMW'(sample);
			end
			if (state_q == swmad_pkg::ST_EVICT) begin
				ptr_q <= ptr_inc;
				sum_q <= sum_q + SUMW'(s_q) - SUMW'($signed(ram_rdata));
			end
			if (finish && out_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s_q        <= sample;
			ev_valid_q <= 1'b0;
			ev_q       <= '0;
		end
		if (state_q == swmad_pkg::ST_EVICT) begin
			ev_valid_q <= 1'b1;
			ev_q       <= $signed(ram_rdata);
		end
		if (state_q == swmad_pkg::ST_MLOAD) begin
			neg_q  <= sum_q[SUMW-1];
			dvd_q  <= {sum_mag, {swmad_pkg::FRAC_W{1'b0}}};
			rem_q  <= '0;
			iter_q <= IW'(SUMW);
		end
		if (state_q == swmad_pkg::ST_MDIV ||
				(state_q == swmad_pkg::ST_ADIV && iter_q != IW'(1))) begin
			dvd_q  <= {dvd_q[DW-2:0], qbit};
			rem_q  <= qbit ? CW'(rem_diff) : CW'(rem_sh);
			iter_q <= iter_q - 1'b1;
		end
		if (state_q == swmad_pkg::ST_MEND) begin
			mean_q       <= neg_q ? SW_'(-quo_mean) : SW_'(quo_mean);
			walk_addr_q  <= ptr_q;
			issue_left_q <= fill_q;
			total_q      <= '0;
		end
		if (state_q == swmad_pkg::ST_WALK) begin
			if (issue_left_q != '0) begin
				walk_addr_q  <= walk_inc;
				issue_left_q <= issue_left_q - 1'b1;
			end
			if (rd_s1) begin
				total_q <= total_q + TW'(dev_abs);
			end
		end
		if (state_q == swmad_pkg::ST_ALOAD) begin
			dvd_q  <= {total_q, {swmad_pkg::FRAC_W{1'b0}}};
			rem_q  <= '0;
			iter_q <= IW'(DW);
		end
		if (finish && out_free) begin
			evicted_valid  <= ev_valid_q;
			evicted_sample <= ev_q;
			window_mean    <= mean_q;
			mean_abs_dev   <= swmad_pkg::MAD_W'({dvd_q[DW-2:0], qbit});
		end
	end

endmodule

`default_nettype wire

[rtl/swmad_checker.sv]
// Port-level checker for the sliding-window mean / deviation top level,
// bound to it below. Depends on swmad_pkg.
`default_nettype none

module swmad_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  sample_valid,
	input wire logic                                  sample_stall,
	input wire logic signed [swmad_pkg::SAMPLE_W-1:0] sample,
	input wire logic                                  result_valid,
	input wire logic                                  result_stall,
	input wire logic                                  evicted_valid,
	input wire logic signed [swmad_pkg::SAMPLE_W-1:0] evicted_sample,
	input wire logic signed [swmad_pkg::MEAN_W-1:0]   window_mean,
	input wire logic        [swmad_pkg::MAD_W-1:0]    mean_abs_dev
);

	logic in_xfer;
	assign in_xfer = sample_valid && !sample_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(evicted_valid) &&
			$stable(evicted_sample) && $stable(window_mean) && $stable(mean_abs_dev))
		else $error("result changed while stalled");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> sample_stall)
		else $error("sample taken while previous item still in work");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !$rose(result_valid))
		else $error("result appeared right after a sample transfer");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !evicted_valid |-> evicted_sample == '0)
		else $error("evicted sample nonzero without eviction");

	a_mad_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> mean_abs_dev <= swmad_pkg::MAD_MAX)
		else $error("deviation out of range");

endmodule

bind sliding_window_mean_abs_deviation_top swmad_checker u_swmad_checker (.*);

`default_nettype wire
